// ===== design/psalru_pkg.sv =====
// Shared types and constants for the page-size-aware LRU replacement block
`default_nettype none
package psalru_pkg;

    localparam int SET_W  = 6;
    localparam int WAY_W  = 4;
    localparam int RANK_W = 4;
    localparam int MASK_W = 16;

    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [1:0] REASON_INVALID = 2'd0;
    localparam logic [1:0] REASON_LRU     = 2'd1;
    localparam logic [1:0] REASON_BASE    = 2'd2;
    localparam logic [1:0] REASON_NONE    = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way_index;
        logic              is_hit;
        logic              is_writeback;
        logic [MASK_W-1:0] valid_mask;
        logic [MASK_W-1:0] base_page_mask;
    } in_t;

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic [1:0]       victim_reason;
    } out_t;

    typedef struct packed {
        logic load_item;
        logic write_row;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_query;
        logic upd_en;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/psalru_dp.sv =====
// Datapath: rank memory, row valid bits, victim selection and rank update
`default_nettype none
module psalru_dp
    import psalru_pkg::*;
#(
    parameter int WAYS = 16,
    parameter int SETS = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_cmd_t  cmd_i,
    output dp_status_t      sts_o,
    input  wire in_t        s_data,
    output out_t            m_data
);

    localparam int MAP_N     = 1 << SET_W;
    localparam int USED_ROWS = (SETS < MAP_N) ? SETS : MAP_N;
    localparam int ROW_W     = (USED_ROWS > 1) ? $clog2(USED_ROWS) : 1;
    localparam int ROW_BITS  = WAYS * RANK_W;

    function automatic logic [MAP_N*ROW_W-1:0] build_row_map();
        logic [MAP_N*ROW_W-1:0] m;
        m = '0;
        for (int i = 0; i < MAP_N; i++) begin
            m[i*ROW_W +: ROW_W] = ROW_W'(i % SETS);
        end
        return m;
    endfunction

    function automatic logic [ROW_BITS-1:0] build_reset_row();
        logic [ROW_BITS-1:0] r;
        r = '0;
        for (int w = 0; w < WAYS; w++) begin
            r[w*RANK_W +: RANK_W] = RANK_W'(w);
        end
        return r;
    endfunction

    localparam logic [MAP_N*ROW_W-1:0] ROW_MAP   = build_row_map();
    localparam logic [ROW_BITS-1:0]    RESET_ROW = build_reset_row();

    logic [ROW_BITS-1:0] rank_mem [USED_ROWS];
    logic [USED_ROWS-1:0] row_vld_reg;

    in_t                 item_reg;
    logic [ROW_W-1:0]    row_idx_reg;
    logic [ROW_BITS-1:0] rd_row_reg;
    logic                rd_vld_reg;
    out_t                out_reg;

    logic [ROW_W-1:0]    rd_idx;
    logic [ROW_BITS-1:0] cur_row;
    logic [RANK_W-1:0]   rank [WAYS];
    logic [WAYS-1:0]     vmask;
    logic [WAYS-1:0]     bpmask;
    logic [WAYS-1:0]     is_lru;
    logic [WAYS-1:0]     in_scan;
    logic [WAYS-1:0]     elig;
    logic [WAYS-1:0]     is_best;
    logic                inv_found;
    logic                lru_found;
    logic                best_found;
    logic [WAY_W-1:0]    inv_way;
    logic [WAY_W-1:0]    lru_way;
    logic [WAY_W-1:0]    best_way;
    out_t                victim;
    logic [RANK_W-1:0]   hit_rank;
    logic [ROW_BITS-1:0] new_row;
    logic                way_ok;

    assign rd_idx = ROW_MAP[int'(s_data.set_index)*ROW_W +: ROW_W];

    always_ff @(posedge aclk) begin
        if (cmd_i.load_item) begin
            item_reg    <= s_data;
            row_idx_reg <= rd_idx;
            rd_row_reg  <= rank_mem[rd_idx];
            rd_vld_reg  <= row_vld_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.write_row) begin
            rank_mem[row_idx_reg] <= new_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (cmd_i.write_row) begin
            row_vld_reg[row_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_out) begin
            out_reg <= victim;
        end
    end

    assign cur_row = rd_vld_reg ? rd_row_reg : RESET_ROW;
    assign vmask   = item_reg.valid_mask[WAYS-1:0];
    assign bpmask  = item_reg.base_page_mask[WAYS-1:0];

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            rank[i]   = cur_row[i*RANK_W +: RANK_W];
            is_lru[i] = (rank[i] == RANK_W'(WAYS - 1));
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            in_scan[i] = 1'b1;
            for (int j = 0; j < i; j++) begin
                if (is_lru[j]) begin
                    in_scan[i] = 1'b0;
                end
            end
            elig[i] = bpmask[i] && in_scan[i] && (rank[i] != '0);
        end
    end

    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            is_best[i] = elig[i];
            for (int j = 0; j < WAYS; j++) begin
                if (elig[j] && (j < i) && (rank[j] >= rank[i])) begin
                    is_best[i] = 1'b0;
                end
                if (elig[j] && (j > i) && (rank[j] > rank[i])) begin
                    is_best[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        inv_way  = '0;
        lru_way  = '0;
        best_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (!vmask[i]) begin
                inv_way = WAY_W'(i);
            end
            if (is_lru[i]) begin
                lru_way = WAY_W'(i);
            end
            if (is_best[i]) begin
                best_way = WAY_W'(i);
            end
        end
    end

    assign inv_found  = ~&vmask;
    assign lru_found  = |is_lru;
    assign best_found = |is_best;

    always_comb begin
        if (inv_found) begin
            victim.victim_way    = inv_way;
            victim.victim_reason = REASON_INVALID;
        end else if (best_found && (!lru_found || (best_way != lru_way))) begin
            victim.victim_way    = best_way;
            victim.victim_reason = REASON_BASE;
        end else if (lru_found) begin
            victim.victim_way    = lru_way;
            victim.victim_reason = REASON_LRU;
        end else begin
            victim.victim_way    = '0;
            victim.victim_reason = REASON_NONE;
        end
    end

    always_comb begin
        hit_rank = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (item_reg.way_index == WAY_W'(i)) begin
                hit_rank = rank[i];
            end
        end
    end

    always_comb begin
        new_row = cur_row;
        for (int i = 0; i < WAYS; i++) begin
            if (item_reg.way_index == WAY_W'(i)) begin
                new_row[i*RANK_W +: RANK_W] = '0;
            end else if (rank[i] <= hit_rank) begin
                new_row[i*RANK_W +: RANK_W] = rank[i] + RANK_W'(1);
            end
        end
    end

    assign way_ok = (int'(item_reg.way_index) < WAYS);

    assign sts_o.is_query = (item_reg.cmd == CMD_QUERY);
    assign sts_o.upd_en   = way_ok && !(item_reg.is_hit && item_reg.is_writeback);

    assign m_data = out_reg;

endmodule
`default_nettype wire

// ===== design/psalru_ctrl.sv =====
// Controller: sequences read, compute and write-back or result load per word
`default_nettype none
module psalru_ctrl
    import psalru_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire dp_status_t  sts_i,
    output ctrl_cmd_t        cmd_o
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd_o        = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_o.load_item = 1'b1;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts_i.is_query) begin
                    if (out_free) begin
                        cmd_o.load_out = 1'b1;
                        m_valid_next   = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    cmd_o.write_row = sts_i.upd_en;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/page_size_aware_lru_replacement.sv =====
// Top level: page-size-aware LRU replacement, controller plus datapath
// Flow: a word is captured in the item register, then a query's result is
//   loaded into the output register or an update's set row is written back;
//   no new word is taken until then, and a query waits while the output holds.
// Reset: synchronous, active low; per-row valid bits clear at once, so every
//   set reads back with each way's rank equal to its way number.
`default_nettype none
module page_size_aware_lru_replacement
    import psalru_pkg::*;
#(
    parameter int WAYS = 16,
    parameter int SETS = 64
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    input  wire in_t   s_data,
    output logic       m_valid,
    input  wire logic  m_ready,
    output out_t       m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    psalru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    psalru_dp #(
        .WAYS (WAYS),
        .SETS (SETS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_i   (cmd),
        .sts_o   (sts),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the page-size-aware LRU replacement block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psalru_pkg::*;

    localparam int NUM_WAYS       = 16;
    localparam int NUM_SETS       = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    logic [RANK_W-1:0] lru_rank [NUM_SETS][NUM_WAYS];
    out_t victim_q[$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int idle_cycles   = 0;
    int query_count   = 0;
    int update_count  = 0;
    int skipped_count = 0;
    int checked_count = 0;
    int mismatches    = 0;
    int unexpected    = 0;
    int reason_count [4];

    page_size_aware_lru_replacement #(
        .WAYS(NUM_WAYS),
        .SETS(NUM_SETS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    function automatic void reset_rank_table();
        for (int s = 0; s < NUM_SETS; s++) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                lru_rank[s][w] = RANK_W'(w);
            end
        end
    endfunction

    function automatic out_t predict_victim(in_t w);
        out_t              res;
        logic [RANK_W-1:0] best_rank;
        int                best_way;
        int                stop_way;
        bit                found;
        logic [RANK_W-1:0] r;

        best_rank = '0;
        best_way  = 0;
        stop_way  = NUM_WAYS;
        found     = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (!found && !w.valid_mask[i]) begin
                res.victim_way    = WAY_W'(i);
                res.victim_reason = REASON_INVALID;
                found             = 1'b1;
            end
        end
        if (found) begin
            return res;
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (stop_way == NUM_WAYS) begin
                r = lru_rank[w.set_index][i];
                if (w.base_page_mask[i] && r > best_rank) begin
                    best_rank = r;
                    best_way  = i;
                end
                if (r == RANK_W'(NUM_WAYS - 1)) begin
                    stop_way = i;
                end
            end
        end
        if (stop_way != best_way && best_rank != 0) begin
            res.victim_way    = WAY_W'(best_way);
            res.victim_reason = REASON_BASE;
        end else if (stop_way < NUM_WAYS) begin
            res.victim_way    = WAY_W'(stop_way);
            res.victim_reason = REASON_LRU;
        end else begin
            res.victim_way    = '0;
            res.victim_reason = REASON_NONE;
        end
        return res;
    endfunction

    function automatic void touch_rank_row(logic [SET_W-1:0] set, logic [WAY_W-1:0] way);
        logic [RANK_W-1:0] hit_rank;

        hit_rank = lru_rank[set][way];
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (lru_rank[set][i] <= hit_rank) begin
                lru_rank[set][i] = lru_rank[set][i] + RANK_W'(1);
            end
        end
        lru_rank[set][way] = '0;
    endfunction

    function automatic void record_word(in_t w);
        if (w.cmd == CMD_QUERY) begin
            victim_q.push_back(predict_victim(w));
            query_count++;
        end else begin
            update_count++;
            if (w.is_hit && w.is_writeback) begin
                skipped_count++;
            end else if (int'(w.way_index) < NUM_WAYS) begin
                touch_rank_row(w.set_index, w.way_index);
            end
        end
    endfunction

    function automatic in_t query_word(int set, logic [MASK_W-1:0] valid,
                                       logic [MASK_W-1:0] base);
        in_t w;
        w                = '0;
        w.cmd            = CMD_QUERY;
        w.set_index      = SET_W'(set);
        w.valid_mask     = valid;
        w.base_page_mask = base;
        return w;
    endfunction

    function automatic in_t update_word(int set, int way, bit hit, bit wb);
        in_t w;
        w              = '0;
        w.cmd          = CMD_UPDATE;
        w.set_index    = SET_W'(set);
        w.way_index    = WAY_W'(way);
        w.is_hit       = hit;
        w.is_writeback = wb;
        return w;
    endfunction

    function automatic in_t random_word();
        in_t w;
        w.cmd            = ($urandom_range(99) < 40) ? CMD_QUERY : CMD_UPDATE;
        w.set_index      = ($urandom_range(99) < 60) ? SET_W'($urandom_range(3))
                                                     : SET_W'($urandom_range(63));
        w.way_index      = WAY_W'($urandom_range(15));
        w.is_hit         = 1'($urandom_range(1));
        w.is_writeback   = w.is_hit ? ($urandom_range(9) == 0) : 1'($urandom_range(1));
        w.base_page_mask = MASK_W'($urandom_range(65535));
        case ($urandom_range(9))
            0: begin
                w.valid_mask = MASK_W'($urandom_range(65535));
            end
            1: begin
                w.valid_mask = ~(MASK_W'(1) << $urandom_range(15));
            end
            default: begin
                w.valid_mask = '1;
            end
        endcase
        return w;
    endfunction

    task automatic send_word(input in_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        record_word(w);
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        out_t exp_word;
        if (aresetn && m_valid && m_ready) begin
            if (victim_q.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS) begin
                    $display("tb: unexpected victim way %0d reason %0d",
                             m_data.victim_way, m_data.victim_reason);
                end
            end else begin
                exp_word = victim_q.pop_front();
                checked_count++;
                reason_count[exp_word.victim_reason]++;
                if (m_data.victim_way !== exp_word.victim_way ||
                    m_data.victim_reason !== exp_word.victim_reason) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS) begin
                        $display({"tb: mismatch: expected way %0d reason %0d, ",
                                  "got way %0d reason %0d"},
                                 exp_word.victim_way, exp_word.victim_reason,
                                 m_data.victim_way, m_data.victim_reason);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: watchdog expired with %0d victims pending", victim_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_invalid_way_queries();
        send_word(query_word(0, 16'h0000, 16'h0000));
        send_word(query_word(5, 16'h7FFF, 16'hFFFF));
        send_word(query_word(63, 16'h8000, 16'h0000));
        send_word(query_word(1, 16'hFF7F, 16'hFFFF));
        send_word(query_word(2, 16'hFFF0, 16'h0F0F));
    endtask

    task automatic test_lru_and_base_page();
        send_word(query_word(0, 16'hFFFF, 16'h0000));
        send_word(query_word(0, 16'hFFFF, 16'hFFFF));
        send_word(query_word(0, 16'hFFFF, 16'h7FFF));
        send_word(query_word(0, 16'hFFFF, 16'h0001));
        send_word(query_word(63, 16'hFFFF, 16'h0002));
    endtask

    task automatic test_access_updates();
        send_word(update_word(0, 15, 1'b0, 1'b0));
        send_word(query_word(0, 16'hFFFF, 16'h0000));
        send_word(update_word(0, 14, 1'b1, 1'b1));
        send_word(query_word(0, 16'hFFFF, 16'h8000));
        send_word(update_word(0, 14, 1'b0, 1'b1));
        send_word(query_word(0, 16'hFFFF, 16'h4000));
        send_word(update_word(63, 0, 1'b1, 1'b0));
        send_word(query_word(63, 16'hFFFF, 16'h0001));
        send_word(update_word(63, 15, 1'b1, 1'b0));
        send_word(query_word(63, 16'hFFFF, 16'hFFFF));
        send_word(update_word(0, 0, 1'b0, 1'b0));
        send_word(query_word(0, 16'hFFFF, 16'h2000));
    endtask

    task automatic test_random_traffic(int count, int sender_idle, int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (count) begin
            send_word(random_word());
        end
    endtask

    initial begin
        reset_rank_table();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_invalid_way_queries();
        test_lru_and_base_page();
        test_access_updates();
        test_random_traffic(350, 0, 0);
        test_random_traffic(350, 64, 0);
        test_random_traffic(350, 0, 64);
        test_random_traffic(350, 23, 23);

        s_valid <= 1'b0;
        while (victim_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d queries and %0d updates sent (%0d write-back hits)",
                 query_count, update_count, skipped_count);
        $display("tb: %0d victims checked; by reason invalid %0d, lru %0d, base page %0d, none %0d",
                 checked_count, reason_count[REASON_INVALID], reason_count[REASON_LRU],
                 reason_count[REASON_BASE], reason_count[REASON_NONE]);
        if (mismatches == 0 && unexpected == 0 && victim_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: %0d mismatches, %0d unexpected victims", mismatches, unexpected);
            $display("tb: failure");
        end
        $finish;
    end

endmodule
